FILE: hdl/face_centroid_interval_binner_defines.svh
// ----------------------------------------------------------------------------
// Face centroid interval binner: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FACE_CENTROID_INTERVAL_BINNER_DEFINES_SVH
`define FACE_CENTROID_INTERVAL_BINNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fcib_pkg.sv
// ----------------------------------------------------------------------------
// fcib_pkg
// Types, widths and codes shared by the face centroid interval binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcib_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int MAX_NODES_DEF     = 9;

  localparam int COORD_W    = 32;
  localparam int SUM_W      = 36;
  localparam int CNT_W      = 4;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  localparam logic [COORD_W-1:0] KEY_SAT = 32'h7FFF_FFFF;

  // Item function codes.
  localparam logic FUNC_BOUND = 1'b0;
  localparam logic FUNC_NODE  = 1'b1;

  // Axis codes.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Measure mode codes.
  localparam logic MODE_AXIAL  = 1'b0;
  localparam logic MODE_RADIAL = 1'b1;

  // Register indexes (word address).
  localparam logic [2:0] REG_MEASURE_MODE   = 3'd0;
  localparam logic [2:0] REG_AXIS_SELECT    = 3'd1;
  localparam logic [2:0] REG_CENTER_X       = 3'd2;
  localparam logic [2:0] REG_CENTER_Y       = 3'd3;
  localparam logic [2:0] REG_CENTER_Z       = 3'd4;
  localparam logic [2:0] REG_INTERVAL_COUNT = 3'd5;

  typedef struct packed {
    logic                      func;
    logic [4:0]                bound_index;
    logic signed [COORD_W-1:0] bound_value;
    logic signed [COORD_W-1:0] node_x;
    logic signed [COORD_W-1:0] node_y;
    logic signed [COORD_W-1:0] node_z;
    logic                      last_node;
  } in_t;

  typedef struct packed {
    logic [3:0]                bin_index;
    logic                      in_range;
    logic signed [COORD_W-1:0] key_value;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQUARE,
    ST_ACCUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_SRCH_GO,
    ST_SRCH_WAIT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/fcib_div.sv
// ----------------------------------------------------------------------------
// fcib_div
// Signed sum divided by a small node count, truncated toward zero.
// Restoring division on the magnitude, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcib_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [fcib_pkg::SUM_W-1:0]   dividend_i,
  input  wire logic        [fcib_pkg::CNT_W-1:0]   divisor_i,
  output logic                                     done_o,
  output logic signed      [fcib_pkg::COORD_W-1:0] quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [fcib_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic                              neg_q;
  logic [fcib_pkg::SUM_W-1:0]        dvd_q, dvd_d;
  logic [fcib_pkg::CNT_W:0]          rem_q, rem_d;
  logic [fcib_pkg::CNT_W-1:0]        dsr_q;
  logic [fcib_pkg::SUM_W-1:0]        mag;
  logic [fcib_pkg::SUM_W-1:0]        q_signed;
  logic signed [fcib_pkg::COORD_W-1:0] quo_q;

  assign mag = dividend_i[fcib_pkg::SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // The remainder always stays below the divisor, so each step is a narrow compare.
  always_comb begin
    logic [fcib_pkg::CNT_W:0] trial;
    logic                     ge;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < fcib_pkg::DIV_STEPS; k++) begin
      trial = {rem_d[fcib_pkg::CNT_W-1:0], dvd_d[fcib_pkg::SUM_W-1]};
      ge    = (trial >= {1'b0, dsr_q});
      dvd_d = {dvd_d[fcib_pkg::SUM_W-2:0], ge};
      rem_d = ge ? (trial - {1'b0, dsr_q}) : trial;
    end
  end

  assign q_signed = neg_q ? (~dvd_d + 1'b1) : dvd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == fcib_pkg::DIV_CNT_W'(fcib_pkg::DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[fcib_pkg::SUM_W-1];
      dvd_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (cnt_q == fcib_pkg::DIV_CNT_W'(fcib_pkg::DIV_CYCLES - 1)) begin
        quo_q <= q_signed[fcib_pkg::COORD_W-1:0];
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hdl/fcib_sqrt.sv
// ----------------------------------------------------------------------------
// fcib_sqrt
// Floored integer square root of a 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcib_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [fcib_pkg::SQ_W-1:0]         radicand_i,
  output logic                                   done_o,
  output logic      [fcib_pkg::ROOT_W-1:0]       root_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [fcib_pkg::SQ_W-1:0]     v_q, res_q, bit_q;
  logic [fcib_pkg::SQ_W-1:0]     trial, v_d, res_d;
  logic [fcib_pkg::ROOT_W-1:0]   root_q;
  logic                          ge;

  assign trial = res_q + bit_q;
  assign ge    = (v_q >= trial);
  assign v_d   = ge ? (v_q - trial) : v_q;
  assign res_d = ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // The test bit walks down two places a cycle; the last step has it at bit zero.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      res_q <= '0;
      bit_q <= fcib_pkg::SQ_W'(1) << (fcib_pkg::SQ_W - 2);
    end else if (busy_q) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_q >> 2;
      if (bit_q[0]) begin
        root_q <= res_d[fcib_pkg::ROOT_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: hdl/fcib_search.sv
// ----------------------------------------------------------------------------
// fcib_search
// Interval bound memory and a linear search for the first interval that
// holds the key, one bound read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcib_search #(
  parameter int MAX_INTERVALS = fcib_pkg::MAX_INTERVALS_DEF,
  localparam int IDX_W = $clog2(MAX_INTERVALS + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic        [IDX_W-1:0]             wr_addr_i,
  input  wire logic signed [fcib_pkg::COORD_W-1:0] wr_data_i,
  input  wire logic                                start_i,
  input  wire logic signed [fcib_pkg::COORD_W-1:0] key_i,
  input  wire logic        [IDX_W-1:0]             count_i,
  output logic                                     done_o,
  output logic                                     found_o,
  output logic             [IDX_W-1:0]             bin_o
);

  localparam int DEPTH = MAX_INTERVALS + 1;

  logic signed [fcib_pkg::COORD_W-1:0] mem_q [DEPTH];
  logic signed [fcib_pkg::COORD_W-1:0] rd_q;
  logic signed [fcib_pkg::COORD_W-1:0] prev_q;
  logic                                rd_en;
  logic [IDX_W-1:0]                    rd_addr;
  logic [IDX_W-1:0]                    idx_q;
  logic [IDX_W-1:0]                    idx_inc;
  logic                                busy_q, done_q, found_q;
  logic [IDX_W-1:0]                    bin_q;
  logic                                hit, last;

  assign idx_inc = IDX_W'(idx_q + 1'b1);

  // rd_q holds bound idx_q; prev_q holds bound idx_q - 1.
  assign hit  = (idx_q != '0) && (key_i >= prev_q) && (key_i <= rd_q);
  assign last = (idx_q == count_i);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (start_i) begin
      rd_en = 1'b1;
    end else if (busy_q && !hit && !last) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        if (hit) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          found_q <= 1'b1;
        end else if (last) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          found_q <= 1'b0;
        end else begin
          idx_q <= idx_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prev_q <= rd_q;
      if (hit) begin
        bin_q <= IDX_W'(idx_q - 1'b1);
      end else if (last) begin
        bin_q <= '0;
      end
    end
  end

  assign done_o  = done_q;
  assign found_o = found_q;
  assign bin_o   = bin_q;

endmodule

`default_nettype wire

FILE: hdl/face_centroid_interval_binner.sv
// ----------------------------------------------------------------------------
// Face centroid interval binner
// Accumulates the nodes of one face, forms the centroid, takes an axial or
// radial key and looks up the first interval whose bounds hold it.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_ready_o  fcib_pkg::in_t
//   out       output     out_valid_o / out_ready_i fcib_pkg::out_t
//   apb       input      psel/penable/pready      paddr, pwdata, prdata
//
// Bound writes and non-final nodes are taken whenever the block is idle. A
// final node holds in_ready_o low while the three divisions run, in radial
// mode also the squares and the square root, and then the bound search; the
// result load follows and waits while the previous result is stalled.
// Reset clears the node sums, the node count and the registers; bounds
// must be written before use. A stalled output keeps its result while the
// block already takes the next items of the following face.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "face_centroid_interval_binner_defines.svh"

module face_centroid_interval_binner #(
  parameter int MAX_INTERVALS = fcib_pkg::MAX_INTERVALS_DEF,
  parameter int MAX_NODES     = fcib_pkg::MAX_NODES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fcib_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fcib_pkg::out_t                       out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fcib_pkg::APB_AW-1:0]     paddr,
  input  wire logic [fcib_pkg::APB_DW-1:0]     pwdata,
  output logic      [fcib_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  localparam int IDX_W = $clog2(MAX_INTERVALS + 1);
  localparam int CW    = fcib_pkg::COORD_W;

  fcib_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic                 mode_q;
  logic [1:0]           axis_q;
  logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;
  logic [4:0]           icount_q;

  logic signed [fcib_pkg::SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic [fcib_pkg::CNT_W-1:0]        cnt_q;
  logic [1:0]                        ax_q;
  logic                              out_valid_q;
  fcib_pkg::out_t                    out_q;

  logic signed [CW-1:0] cent_x_q, cent_y_q, cent_z_q;
  logic [61:0]          prod_q;
  logic [fcib_pkg::SQ_W-1:0] acc_q;
  logic                 sat_q;
  logic signed [CW-1:0] key_q;

  logic in_acc, node_acc, cfg_wr, out_load;
  logic div_start, sqrt_start, srch_start;

  logic signed [fcib_pkg::SUM_W-1:0] div_dividend;
  logic [fcib_pkg::CNT_W-1:0]        div_divisor;
  logic                              div_done;
  logic signed [CW-1:0]              div_quo;
  logic                              sqrt_done;
  logic [fcib_pkg::ROOT_W-1:0]       sqrt_root;
  logic                              srch_done, srch_found;
  logic [IDX_W-1:0]                  srch_bin;
  logic [IDX_W-1:0]                  eff_count;
  logic                              bnd_wr;

  logic signed [CW-1:0] cent_sel, center_sel, axial_key;
  logic signed [CW:0]   diff;
  logic [CW:0]          mag;
  logic                 ovf;
  logic [CW-2:0]        mag_lo;
  logic [61:0]          sq;

  assign in_acc   = in_valid_i && in_ready_o;
  assign node_acc = in_acc && (in_data_i.func == fcib_pkg::FUNC_NODE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // ---------------------------------------------------------------- APB
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= fcib_pkg::MODE_AXIAL;
      axis_q     <= fcib_pkg::AX_X;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      icount_q   <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        fcib_pkg::REG_MEASURE_MODE:   mode_q     <= pwdata[0];
        fcib_pkg::REG_AXIS_SELECT:    axis_q     <= pwdata[1:0];
        fcib_pkg::REG_CENTER_X:       center_x_q <= pwdata;
        fcib_pkg::REG_CENTER_Y:       center_y_q <= pwdata;
        fcib_pkg::REG_CENTER_Z:       center_z_q <= pwdata;
        fcib_pkg::REG_INTERVAL_COUNT: icount_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fcib_pkg::REG_MEASURE_MODE:   prdata = 32'(mode_q);
      fcib_pkg::REG_AXIS_SELECT:    prdata = 32'(axis_q);
      fcib_pkg::REG_CENTER_X:       prdata = center_x_q;
      fcib_pkg::REG_CENTER_Y:       prdata = center_y_q;
      fcib_pkg::REG_CENTER_Z:       prdata = center_z_q;
      fcib_pkg::REG_INTERVAL_COUNT: prdata = 32'(icount_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcib_pkg::ST_IDLE: begin
        if (node_acc && in_data_i.last_node) state_d = fcib_pkg::ST_DIV_GO;
      end
      fcib_pkg::ST_DIV_GO:  state_d = fcib_pkg::ST_DIV_WAIT;
      fcib_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (ax_q != fcib_pkg::AX_Z)                   state_d = fcib_pkg::ST_DIV_GO;
          else if (mode_q == fcib_pkg::MODE_RADIAL)     state_d = fcib_pkg::ST_SQUARE;
          else                                          state_d = fcib_pkg::ST_SRCH_GO;
        end
      end
      fcib_pkg::ST_SQUARE: state_d = fcib_pkg::ST_ACCUM;
      fcib_pkg::ST_ACCUM: begin
        state_d = (ax_q == fcib_pkg::AX_Z) ? fcib_pkg::ST_SQRT_GO : fcib_pkg::ST_SQUARE;
      end
      fcib_pkg::ST_SQRT_GO: state_d = fcib_pkg::ST_SQRT_WAIT;
      fcib_pkg::ST_SQRT_WAIT: begin
        if (sqrt_done) state_d = fcib_pkg::ST_SRCH_GO;
      end
      fcib_pkg::ST_SRCH_GO: state_d = fcib_pkg::ST_SRCH_WAIT;
      fcib_pkg::ST_SRCH_WAIT: begin
        if (srch_done) state_d = fcib_pkg::ST_OUT;
      end
      fcib_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = fcib_pkg::ST_IDLE;
      end
      default: state_d = fcib_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == fcib_pkg::ST_IDLE);
    div_start  = (state_q == fcib_pkg::ST_DIV_GO);
    sqrt_start = (state_q == fcib_pkg::ST_SQRT_GO);
    srch_start = (state_q == fcib_pkg::ST_SRCH_GO);
    out_load   = (state_q == fcib_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcib_pkg::ST_IDLE;
      ax_q        <= fcib_pkg::AX_X;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (node_acc && (cnt_q < fcib_pkg::CNT_W'(MAX_NODES))) begin
        sum_x_q <= sum_x_q + fcib_pkg::SUM_W'(in_data_i.node_x);
        sum_y_q <= sum_y_q + fcib_pkg::SUM_W'(in_data_i.node_y);
        sum_z_q <= sum_z_q + fcib_pkg::SUM_W'(in_data_i.node_z);
        cnt_q   <= cnt_q + 1'b1;
      end
      if ((state_q == fcib_pkg::ST_DIV_WAIT && div_done) ||
          (state_q == fcib_pkg::ST_ACCUM)) begin
        ax_q <= (ax_q == fcib_pkg::AX_Z) ? fcib_pkg::AX_X : ax_q + 1'b1;
      end
      // The face is closed once the last centroid coordinate is out.
      if (state_q == fcib_pkg::ST_DIV_WAIT && div_done && ax_q == fcib_pkg::AX_Z) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        cnt_q   <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- datapath
  always_comb begin
    unique case (ax_q)
      fcib_pkg::AX_X: begin
        div_dividend = sum_x_q;
        cent_sel     = cent_x_q;
        center_sel   = center_x_q;
      end
      fcib_pkg::AX_Y: begin
        div_dividend = sum_y_q;
        cent_sel     = cent_y_q;
        center_sel   = center_y_q;
      end
      default: begin
        div_dividend = sum_z_q;
        cent_sel     = cent_z_q;
        center_sel   = center_z_q;
      end
    endcase
  end

  assign div_divisor = (cnt_q == '0) ? fcib_pkg::CNT_W'(1) : cnt_q;

  always_comb begin
    unique case (axis_q)
      fcib_pkg::AX_X: axial_key = cent_x_q;
      fcib_pkg::AX_Y: axial_key = cent_y_q;
      default:        axial_key = cent_z_q;
    endcase
  end

  // Distances of 2^31 or more on any axis saturate the key outright.
  assign diff   = (CW + 1)'(cent_sel) - (CW + 1)'(center_sel);
  assign mag    = diff[CW] ? (~diff + 1'b1) : diff;
  assign ovf    = |mag[CW:CW-1];
  assign mag_lo = mag[CW-2:0];
  assign sq     = mag_lo * mag_lo;

  always_ff @(posedge clk_i) begin
    if (state_q == fcib_pkg::ST_DIV_WAIT && div_done) begin
      unique case (ax_q)
        fcib_pkg::AX_X: cent_x_q <= div_quo;
        fcib_pkg::AX_Y: cent_y_q <= div_quo;
        default:        cent_z_q <= div_quo;
      endcase
    end
    if (state_q == fcib_pkg::ST_SQUARE) begin
      prod_q <= sq;
      sat_q  <= (ax_q == fcib_pkg::AX_X) ? ovf : (sat_q | ovf);
    end
    if (state_q == fcib_pkg::ST_ACCUM) begin
      acc_q <= ((ax_q == fcib_pkg::AX_X) ? '0 : acc_q) + fcib_pkg::SQ_W'(prod_q);
    end
    if (state_q == fcib_pkg::ST_SRCH_GO && mode_q == fcib_pkg::MODE_AXIAL) begin
      key_q <= axial_key;
    end
    if (state_q == fcib_pkg::ST_SQRT_WAIT && sqrt_done) begin
      key_q <= (sat_q || sqrt_root[fcib_pkg::ROOT_W-1]) ? fcib_pkg::KEY_SAT : sqrt_root;
    end
    if (out_load) begin
      out_q.bin_index <= srch_found ? 4'(srch_bin) : 4'd0;
      out_q.in_range  <= srch_found;
      out_q.key_value <= key_q;
    end
  end

  // A count of zero acts as one; counts above the bound store are clipped.
  always_comb begin
    if (icount_q == '0) begin
      eff_count = IDX_W'(1);
    end else if (32'(icount_q) > 32'(MAX_INTERVALS)) begin
      eff_count = IDX_W'(MAX_INTERVALS);
    end else begin
      eff_count = IDX_W'(icount_q);
    end
  end

  assign bnd_wr = in_acc && (in_data_i.func == fcib_pkg::FUNC_BOUND) &&
                  (32'(in_data_i.bound_index) <= 32'(MAX_INTERVALS));

  fcib_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  fcib_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  fcib_search #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (bnd_wr),
    .wr_addr_i (IDX_W'(in_data_i.bound_index)),
    .wr_data_i (in_data_i.bound_value),
    .start_i   (srch_start),
    .key_i     (key_q),
    .count_i   (eff_count),
    .done_o    (srch_done),
    .found_o   (srch_found),
    .bin_o     (srch_bin)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------- assertions
  `FCIB_ASSERT_NOW(a_div_done_waited, div_done, state_q == fcib_pkg::ST_DIV_WAIT, "divider finished outside its wait state")
  `FCIB_ASSERT_NOW(a_srch_done_waited, srch_done, state_q == fcib_pkg::ST_SRCH_WAIT, "search finished outside its wait state")
  `FCIB_ASSERT_NOW(a_sqrt_radial_only, state_q == fcib_pkg::ST_SQRT_GO, mode_q == fcib_pkg::MODE_RADIAL, "square root started in axial mode")
  `FCIB_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_q <= fcib_pkg::CNT_W'(MAX_NODES), "node count above its limit")
  `FCIB_ASSERT_NEXT(a_last_starts_div, node_acc && in_data_i.last_node, state_q == fcib_pkg::ST_DIV_GO && cnt_q != '0, "last node did not start the division")

endmodule

`default_nettype wire
